### sv/edge_coverage_map_counter_core_assert.svh
// assertion macros for the edge coverage map counter
// used by the top level only, no other dependencies
`ifndef EDGE_COVERAGE_MAP_COUNTER_CORE_ASSERT_SVH
`define EDGE_COVERAGE_MAP_COUNTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// a holds in a cycle, so b holds in the same cycle
`define ECMC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication violated");

// a holds in a cycle, so b holds in the next one
`define ECMC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication violated");

// a never holds
`define ECMC_ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("forbidden condition seen");

`else

`define ECMC_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ECMC_ASSERT_NEXT(label, clk, rst_n, a, b)
`define ECMC_ASSERT_NEVER(label, clk, rst_n, a)

`endif

`endif

### sv/ecmc_pkg.sv
// shared constants and types of the edge coverage map counter
// no dependencies
package ecmc_pkg;

	localparam int PC_W  = 64;
	localparam int CPU_W = 6;
	localparam int IDX_W = 16;
	localparam int CNT_W = 8;

	// map size is a power of two, the slot is the top MAP_AW bits of the 64-bit hash
	localparam int MAP_AW   = 16;
	localparam int MAP_SIZE = 1 << MAP_AW;

	localparam int NUM_CPUS = 8;
	localparam int CPU_AW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

	localparam logic [PC_W-1:0] GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [31:0]     GOLDEN_LO  = GOLDEN[31:0];
	localparam logic [31:0]     GOLDEN_HI  = GOLDEN[63:32];
	localparam int              HASH_SHIFT = 48;

	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// work handed from front to back: xor key for a record, index for a read
	typedef struct packed {
		logic            is_read;
		logic [PC_W-1:0] key;
	} job_t;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
	} status_t;

endpackage

### sv/ecmc_if.sv
// trace input and result output channels of the edge coverage map counter
// depends on ecmc_pkg
interface ecmc_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [ecmc_pkg::CPU_W-1:0] cpu_number;
	logic [ecmc_pkg::PC_W-1:0]  program_counter;
	logic                       controller_on;
	logic                       task_is_controller;
	logic [ecmc_pkg::IDX_W-1:0] read_index;

	modport source (
		output valid, kind, cpu_number, program_counter, controller_on,
			task_is_controller, read_index,
		input  ready
	);
	modport sink (
		input  valid, kind, cpu_number, program_counter, controller_on,
			task_is_controller, read_index,
		output ready
	);
endinterface

interface ecmc_out_if;
	logic                       valid;
	logic                       ready;
	logic [ecmc_pkg::CNT_W-1:0] entry_count;
	logic [ecmc_pkg::IDX_W-1:0] entry_index;

	modport source (output valid, entry_count, entry_index, input ready);
	modport sink (input valid, entry_count, entry_index, output ready);
endinterface

### sv/ecmc_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module ecmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/ecmc_front.sv
// front end: accepts trace items, filters them, keeps the previous pc per cpu
// depends on ecmc_pkg and ecmc_if
module ecmc_front (
	input  logic              clk,
	input  logic              arst_n,
	ecmc_in_if.sink           trace,
	input  ecmc_pkg::status_t status,
	output logic              push_valid,
	input  logic              push_ready,
	output ecmc_pkg::job_t    push_job
);

	logic [ecmc_pkg::PC_W-1:0]   prev_pc_q [ecmc_pkg::NUM_CPUS];
	logic                        accept;
	logic                        cpu_in_range;
	logic                        cpu_allowed;
	logic                        record_ok;
	logic                        is_read;
	logic [ecmc_pkg::CPU_AW-1:0] cpu_idx;

	assign trace.ready  = !status.clearing && push_ready;
	assign accept       = trace.valid && trace.ready;
	assign is_read      = (trace.kind == ecmc_pkg::KIND_READ);
	assign cpu_idx      = trace.cpu_number[ecmc_pkg::CPU_AW-1:0];
	assign cpu_in_range = ({1'b0, trace.cpu_number} <
		(ecmc_pkg::CPU_W + 1)'(ecmc_pkg::NUM_CPUS));
	// cpu 0 only counts inside the controller window
	assign cpu_allowed  = (trace.cpu_number != '0) ||
		(trace.controller_on && trace.task_is_controller);
	assign record_ok    = !is_read && cpu_in_range && cpu_allowed;

	assign push_valid       = accept && (is_read || record_ok);
	assign push_job.is_read = is_read;
	assign push_job.key     = is_read
		? {{(ecmc_pkg::PC_W - ecmc_pkg::IDX_W){1'b0}}, trace.read_index}
		: (prev_pc_q[cpu_idx] ^ trace.program_counter);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ecmc_pkg::NUM_CPUS; i++) begin
				prev_pc_q[i] <= '0;
			end
		end else if (accept && record_ok) begin
			prev_pc_q[cpu_idx] <= trace.program_counter;
		end
	end

endmodule

### sv/ecmc_queue.sv
// short fifo of jobs between front and back end
// depends on ecmc_pkg
module ecmc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ecmc_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ecmc_pkg::job_t pop_job
);

	ecmc_pkg::job_t              entry_q [ecmc_pkg::QUEUE_DEPTH];
	logic [ecmc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ecmc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ecmc_pkg::QPTR_W:0]   count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (count_q != (ecmc_pkg::QPTR_W + 1)'(ecmc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ecmc_pkg::QPTR_W'(ecmc_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ecmc_pkg::QPTR_W'(ecmc_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/ecmc_back.sv
// back end: clears the map, hashes edges with a shared 32x32 multiplier,
// updates and reads the counters; depends on ecmc_pkg, ecmc_if, ecmc_ram
module ecmc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  ecmc_pkg::job_t     pop_job,
	output ecmc_pkg::status_t  status,
	ecmc_out_if.source         result
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_LOOK,
		S_WRITE,
		S_READ,
		S_SEND
	} state_t;

	state_t                      state_q;
	ecmc_pkg::job_t              job_q;
	logic [ecmc_pkg::MAP_AW-1:0] clr_q;
	logic [ecmc_pkg::MAP_AW-1:0] slot_q;
	logic [63:0]                 prod_q;
	logic [31:0]                 acc_q;
	logic                        out_valid_q;
	logic [ecmc_pkg::CNT_W-1:0]  count_q;
	logic [ecmc_pkg::IDX_W-1:0]  index_q;

	logic [31:0]                 mul_a;
	logic [31:0]                 mul_b;
	logic [63:0]                 mul_p;
	logic [31:0]                 hash_sum;
	logic [ecmc_pkg::MAP_AW-1:0] slot;
	logic [ecmc_pkg::IDX_W-1:0]  job_idx;
	logic                        out_of_map;
	logic                        out_free;
	logic                        ram_we;
	logic [ecmc_pkg::MAP_AW-1:0] ram_waddr;
	logic [ecmc_pkg::CNT_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [ecmc_pkg::MAP_AW-1:0] ram_raddr;
	logic [ecmc_pkg::CNT_W-1:0]  ram_rdata;

	// low 64 bits of key * golden: lo*lo full, cross terms only mod 2^32
	assign mul_a = (state_q == S_MUL1) ? job_q.key[63:32] : job_q.key[31:0];
	assign mul_b = (state_q == S_MUL2) ? ecmc_pkg::GOLDEN_HI : ecmc_pkg::GOLDEN_LO;
	assign mul_p = mul_a * mul_b;

	assign hash_sum   = acc_q + prod_q[31:0];
	assign slot       = hash_sum[ecmc_pkg::HASH_SHIFT - 32 +: ecmc_pkg::MAP_AW];
	assign job_idx    = job_q.key[ecmc_pkg::IDX_W-1:0];
	assign out_of_map = ({1'b0, job_idx} >= (ecmc_pkg::IDX_W + 1)'(ecmc_pkg::MAP_SIZE));
	assign out_free   = !out_valid_q || result.ready;

	assign pop_ready       = (state_q == S_IDLE);
	assign status.clearing = (state_q == S_CLEAR);

	assign result.valid       = out_valid_q;
	assign result.entry_count = count_q;
	assign result.entry_index = index_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = (ram_rdata == ecmc_pkg::COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
		ram_re    = 1'b0;
		ram_raddr = slot;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_LOOK: begin
				ram_re = 1'b1;
			end
			S_WRITE: begin
				ram_we = 1'b1;
			end
			S_READ: begin
				ram_re    = 1'b1;
				ram_raddr = job_idx[ecmc_pkg::MAP_AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	ecmc_ram #(
		.WIDTH (ecmc_pkg::CNT_W),
		.DEPTH (ecmc_pkg::MAP_SIZE)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			job_q <= pop_job;
		end
		if (state_q == S_MUL0 || state_q == S_MUL1 || state_q == S_MUL2) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MUL1) begin
			acc_q <= prod_q[63:32];
		end
		if (state_q == S_MUL2) begin
			acc_q <= hash_sum;
		end
		if (state_q == S_LOOK) begin
			slot_q <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			index_q     <= '0;
		end else begin
			if (state_q == S_SEND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ecmc_pkg::MAP_AW'(ecmc_pkg::MAP_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= pop_job.is_read ? S_READ : S_MUL0;
					end
				end
				S_MUL0:  state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_LOOK;
				S_LOOK:  state_q <= S_WRITE;
				S_WRITE: state_q <= S_IDLE;
				S_READ:  state_q <= S_SEND;
				S_SEND: begin
					// read data stays in the ram output register until taken
					if (out_free) begin
						count_q <= out_of_map ? '0 : ram_rdata;
						index_q <= job_idx;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/edge_coverage_map_counter_core.sv
// Edge coverage map counter. Record items hash the xor of a cpu's previous and
// current pc into a map of 65536 saturating byte counters; read items return one
// counter on the result channel. The front end takes one item per cycle into a
// two-entry queue while the queue has room and the map is not being cleared.
// The back end takes a record through queue pop, three passes through one shared
// 32x32 multiplier, counter read and counter write, and a read through pop, map
// read and result load, plus any wait for the result register; it pops no new
// item until the last is done, so the multiplier and the read-modify-write of the
// map ram set its rate. Items from cpu 0 count only when controller_on and
// task_is_controller are both set; cpu numbers of NUM_CPUS or more are ignored.
// After reset the map is cleared one entry per cycle, while trace.ready stays low.
// depends on ecmc_pkg, ecmc_if, ecmc_front, ecmc_queue, ecmc_back
`include "edge_coverage_map_counter_core_assert.svh"

module edge_coverage_map_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	ecmc_in_if.sink     trace,
	ecmc_out_if.source  result
);

	ecmc_pkg::status_t status;
	ecmc_pkg::job_t    push_job;
	ecmc_pkg::job_t    pop_job;
	logic              push_valid;
	logic              push_ready;
	logic              pop_valid;
	logic              pop_ready;

	ecmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.trace      (trace),
		.status     (status),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	ecmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	ecmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.status    (status),
		.result    (result)
	);

	// no trace transfer while the map is being cleared
	`ECMC_ASSERT_IMPLIES(a_no_accept_in_clear, clk, arst_n, status.clearing, !trace.ready)
	// front never pushes into a full queue
	`ECMC_ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push_valid && !push_ready)
	// queue holds nothing until the clear pass is over
	`ECMC_ASSERT_IMPLIES(a_queue_empty_in_clear, clk, arst_n, status.clearing, !pop_valid)
	// once cleared, the map never goes back to clearing
	`ECMC_ASSERT_NEXT(a_clear_once, clk, arst_n, !status.clearing, !status.clearing)

endmodule
